@@ rtl/triangle_angles_from_vertices_assert.svh @@
// assertion macros for the triangle angle block
// used by files that hold concurrent assertions, needs i_clk and i_rst_n in scope
`ifndef TRIANGLE_ANGLES_FROM_VERTICES_ASSERT_SVH
`define TRIANGLE_ANGLES_FROM_VERTICES_ASSERT_SVH

// same-cycle implication
`define TAV_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TAV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tav_pkg.sv @@
// package of the triangle angle block: payload types, fixed-point constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tav_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int QB          = 60;
    localparam int MAX_TERMS   = 256;
    localparam int NORM_LIM    = 1 << 29;

    localparam logic [63:0] ONE_Q     = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_HALF_Q = 64'h1921_FB54_442D_1847;
    localparam logic [63:0] SWITCH_Q  = 64'd1037629354146162278;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
    } t_tri_in;

    typedef struct packed {
        logic [31:0] angle_a;
        logic [31:0] angle_b;
        logic [31:0] angle_c;
        logic        degenerate;
    } t_tri_out;

    typedef struct packed {
        logic start;
        logic frac;
    } t_div_ctl;

endpackage

`default_nettype wire

@@ rtl/tav_mul.sv @@
// 64 x 64 multiplier that sums its 32 x 32 partial products in turn through one multiplier
// standalone, no package needed
`timescale 1ns / 1ps
`default_nettype none

module tav_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [1:0]   r_idx;
    logic         r_run;
    logic         r_done;
    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        w_pa = r_idx[1] ? r_a[63:32] : r_a[31:0];
        w_pb = r_idx[0] ? r_b[63:32] : r_b[31:0];
        w_pp = w_pa * w_pb;
        unique case (r_idx)
            2'd0:    w_sh = {64'd0, w_pp};
            2'd1,
            2'd2:    w_sh = {32'd0, w_pp, 32'd0};
            2'd3:    w_sh = {w_pp, 64'd0};
            default: w_sh = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_run) begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= '0;
                r_idx <= 2'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_acc <= r_acc + w_sh;
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ rtl/tav_div.sv @@
// restoring divider, one quotient bit a cycle, integer or fraction mode
// depends on tav_pkg
`timescale 1ns / 1ps
`default_nettype none

module tav_div import tav_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_ctl    i_ctl,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);

    localparam logic [6:0] INT_STEPS  = 7'd64;
    localparam logic [6:0] FRAC_STEPS = 7'(QB);

    logic [63:0] r_rem;
    logic [63:0] r_dvd;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [64:0] w_t;
    logic [64:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_t    = {r_rem, r_dvd[63]};
        w_diff = w_t - {1'b0, r_den};
        w_ge   = (w_t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_run) begin
                r_den <= i_den;
                r_quo <= '0;
                r_run <= 1'b1;
                if (i_ctl.frac) begin
                    r_rem <= i_num;
                    r_dvd <= '0;
                    r_cnt <= FRAC_STEPS;
                end else begin
                    r_rem <= '0;
                    r_dvd <= i_num;
                    r_cnt <= INT_STEPS;
                end
            end else if (r_run) begin
                r_rem <= w_ge ? w_diff[63:0] : w_t[63:0];
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_quo <= {r_quo[62:0], w_ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ rtl/tav_sqrt.sv @@
// floor square root of a 128-bit value, one root bit a cycle
// standalone, no package needed
`timescale 1ns / 1ps
`default_nettype none

module tav_sqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_rad,
    output logic         o_done,
    output logic [63:0]  o_root
);

    logic [127:0] r_rad;
    logic [64:0]  r_rem;
    logic [63:0]  r_root;
    logic [6:0]   r_cnt;
    logic         r_run;
    logic         r_done;
    logic [66:0]  w_t;
    logic [66:0]  w_trial;
    logic [66:0]  w_diff;
    logic         w_ge;

    always_comb begin
        w_t     = {r_rem, r_rad[127:126]};
        w_trial = {1'b0, r_root, 2'b01};
        w_diff  = w_t - w_trial;
        w_ge    = (w_t >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_run) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 7'd64;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_rem  <= w_ge ? w_diff[64:0] : w_t[64:0];
                r_root <= {r_root[62:0], w_ge};
                r_rad  <= {r_rad[125:0], 2'b00};
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ rtl/triangle_angles_from_vertices.sv @@
// top level: sequencer driving the shared multiplier, divider and square root
// depends on tav_pkg, tav_mul, tav_div, tav_sqrt and the assertion header
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_angles_from_vertices_assert.svh"

// A transaction is taken when start is high and busy is low; busy then stays high
// until the result is shown on o_result for one cycle with o_strobe, which the
// receiver must take at once. An item ends after the scale check when all vertices
// coincide, after the side lengths for any other degenerate triangle, and otherwise
// runs through scale normalization, three side lengths, then per angle a multiply,
// at most one division, an optional square root, and an arcsine series of up to
// 256 terms. The term count sets the run time, and within a term the three passes
// through the bit-serial divider dominate.
module triangle_angles_from_vertices import tav_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 30
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_tri_in  i_data,
    output logic     busy,
    output logic     o_strobe,
    output t_tri_out o_result
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int MW  = (DW > 31) ? DW : 31;
    localparam int RSH = QB - ANGLE_FRAC_BITS;
    localparam logic [63:0] RND = 64'd1 << (RSH - 1);
    localparam logic [MW-1:0] LIM_HI = MW'(NORM_LIM);
    localparam logic [MW-1:0] LIM_LO = MW'(NORM_LIM / 2);
    localparam logic [8:0] N_LAST = 9'(MAX_TERMS);

    typedef enum logic [4:0] {
        S_IDLE, S_NMAX, S_NSHIFT, S_NFIX, S_SQU, S_SQV, S_LEN, S_TRI,
        S_DEN, S_DIVR, S_AMAG, S_YMUL, S_YSQRT, S_SXX, S_SDIV1, S_SMUL1,
        S_SDIV2, S_SMUL2, S_SMUL3, S_SDIV3, S_SACC, S_SFIN, S_AFIN, S_DONE
    } t_state;

    t_state        r_state;
    logic          r_issued;
    logic [MW-1:0] r_mag [6];
    logic [5:0]    r_neg;
    logic [MW-1:0] r_m;
    logic          r_down;
    logic [1:0]    r_i;
    logic [63:0]   r_sq [3];
    logic [31:0]   r_ln [3];
    logic [63:0]   r_t;
    logic [63:0]   r_den;
    logic          r_num_neg;
    logic [63:0]   r_u;
    logic          r_flip;
    logic [63:0]   r_xx;
    logic [63:0]   r_p;
    logic [63:0]   r_c;
    logic [63:0]   r_q;
    logic [63:0]   r_sum;
    logic [8:0]    r_n;
    logic [63:0]   r_asin;
    logic [31:0]   r_ang [3];
    logic          r_degen;
    logic          r_strobe;
    t_tri_out      r_result;

    logic signed [DW-1:0] w_d [6];
    logic [MW-1:0]        w_dmag [6];
    logic [MW-1:0]        w_max;
    logic signed [MW+1:0] w_s0, w_s1, w_s2, w_s3, w_f4, w_f5;
    logic signed [63:0]   w_num;
    logic [63:0]          w_nmag;
    logic [31:0]          w_lnp, w_lnq;
    logic                 w_rone;
    logic [9:0]           w_2n, w_2nm1, w_2np1;
    logic [63:0]          w_mulq;
    logic [63:0]          w_ang;
    logic [63:0]          w_rnd;
    logic [32:0]          w_l01, w_l02, w_l12;
    logic                 w_degen_tri;

    logic         w_mul_go, w_mul_done;
    logic [63:0]  w_mul_a, w_mul_b;
    logic [127:0] w_prod;
    t_div_ctl     w_div_ctl;
    logic [63:0]  w_div_num, w_div_den, w_quo, w_rem;
    logic         w_div_go, w_div_done;
    logic         w_sqrt_go, w_sqrt_done;
    logic [127:0] w_rad;
    logic [63:0]  w_root;

    tav_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_go),
        .i_a(w_mul_a), .i_b(w_mul_b), .o_done(w_mul_done), .o_prod(w_prod)
    );

    tav_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl),
        .i_num(w_div_num), .i_den(w_div_den),
        .o_done(w_div_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    tav_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sqrt_go),
        .i_rad(w_rad), .o_done(w_sqrt_done), .o_root(w_root)
    );

    // edge vectors AB, AC, BC
    always_comb begin
        w_d[0] = {i_data.b_x[COORD_WIDTH-1], i_data.b_x} - {i_data.a_x[COORD_WIDTH-1], i_data.a_x};
        w_d[1] = {i_data.b_y[COORD_WIDTH-1], i_data.b_y} - {i_data.a_y[COORD_WIDTH-1], i_data.a_y};
        w_d[2] = {i_data.c_x[COORD_WIDTH-1], i_data.c_x} - {i_data.a_x[COORD_WIDTH-1], i_data.a_x};
        w_d[3] = {i_data.c_y[COORD_WIDTH-1], i_data.c_y} - {i_data.a_y[COORD_WIDTH-1], i_data.a_y};
        w_d[4] = {i_data.c_x[COORD_WIDTH-1], i_data.c_x} - {i_data.b_x[COORD_WIDTH-1], i_data.b_x};
        w_d[5] = {i_data.c_y[COORD_WIDTH-1], i_data.c_y} - {i_data.b_y[COORD_WIDTH-1], i_data.b_y};
        for (int k = 0; k < 6; k++) begin
            w_dmag[k] = MW'(w_d[k][DW-1] ? DW'(-w_d[k]) : DW'(w_d[k]));
        end
        w_max = '0;
        for (int k = 0; k < 6; k++) begin
            if (r_mag[k] > w_max) w_max = r_mag[k];
        end
    end

    always_comb begin
        w_s0 = r_neg[0] ? -$signed({2'b00, r_mag[0]}) : $signed({2'b00, r_mag[0]});
        w_s1 = r_neg[1] ? -$signed({2'b00, r_mag[1]}) : $signed({2'b00, r_mag[1]});
        w_s2 = r_neg[2] ? -$signed({2'b00, r_mag[2]}) : $signed({2'b00, r_mag[2]});
        w_s3 = r_neg[3] ? -$signed({2'b00, r_mag[3]}) : $signed({2'b00, r_mag[3]});
        w_f4 = w_s2 - w_s0;
        w_f5 = w_s3 - w_s1;
    end

    always_comb begin
        unique case (r_i)
            2'd0: begin
                w_num = $signed(r_sq[0]) + $signed(r_sq[1]) - $signed(r_sq[2]);
                w_lnp = r_ln[0];
                w_lnq = r_ln[1];
            end
            2'd1: begin
                w_num = $signed(r_sq[0]) + $signed(r_sq[2]) - $signed(r_sq[1]);
                w_lnp = r_ln[0];
                w_lnq = r_ln[2];
            end
            2'd2: begin
                w_num = $signed(r_sq[1]) + $signed(r_sq[2]) - $signed(r_sq[0]);
                w_lnp = r_ln[1];
                w_lnq = r_ln[2];
            end
            default: begin
                w_num = '0;
                w_lnp = '0;
                w_lnq = '0;
            end
        endcase
        w_nmag = w_num[63] ? 64'(-w_num) : 64'(w_num);
        w_rone = (w_nmag >= r_den);
        w_2n   = {r_n, 1'b0};
        w_2nm1 = w_2n - 10'd1;
        w_2np1 = w_2n + 10'd1;
        w_mulq = w_prod[123:60];
        w_ang  = r_num_neg ? (PI_HALF_Q + r_asin) : (PI_HALF_Q - r_asin);
        w_rnd  = (w_ang + RND) >> RSH;
        w_l01  = {1'b0, r_ln[0]} + {1'b0, r_ln[1]};
        w_l02  = {1'b0, r_ln[0]} + {1'b0, r_ln[2]};
        w_l12  = {1'b0, r_ln[1]} + {1'b0, r_ln[2]};
        w_degen_tri = (r_sq[0] == 64'd0) || (r_sq[1] == 64'd0) || (r_sq[2] == 64'd0)
                   || (w_l01 <= {1'b0, r_ln[2]}) || (w_l02 <= {1'b0, r_ln[1]})
                   || (w_l12 <= {1'b0, r_ln[0]});
    end

    // unit requests and operand selection
    always_comb begin
        w_mul_go  = 1'b0;
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_div_go  = 1'b0;
        w_div_ctl = '{start: 1'b0, frac: 1'b0};
        w_div_num = '0;
        w_div_den = '0;
        w_sqrt_go = 1'b0;
        w_rad     = '0;
        unique case (r_state)
            S_SQU: begin
                w_mul_go = !r_issued;
                w_mul_a  = 64'(r_mag[{r_i, 1'b0}]);
                w_mul_b  = 64'(r_mag[{r_i, 1'b0}]);
            end
            S_SQV: begin
                w_mul_go = !r_issued;
                w_mul_a  = 64'(r_mag[{r_i, 1'b1}]);
                w_mul_b  = 64'(r_mag[{r_i, 1'b1}]);
            end
            S_DEN: begin
                w_mul_go = !r_issued;
                w_mul_a  = 64'(w_lnp);
                w_mul_b  = 64'(w_lnq);
            end
            S_YMUL, S_SXX: begin
                w_mul_go = !r_issued;
                w_mul_a  = r_u;
                w_mul_b  = r_u;
            end
            S_SMUL1: begin
                w_mul_go = !r_issued;
                w_mul_a  = r_q;
                w_mul_b  = 64'(w_2nm1);
            end
            S_SMUL2: begin
                w_mul_go = !r_issued;
                w_mul_a  = r_p;
                w_mul_b  = r_xx;
            end
            S_SMUL3: begin
                w_mul_go = !r_issued;
                w_mul_a  = r_c;
                w_mul_b  = r_p;
            end
            S_DIVR: begin
                w_div_go  = !r_issued && !w_rone;
                w_div_ctl = '{start: w_div_go, frac: 1'b1};
                w_div_num = w_nmag;
                w_div_den = r_den;
            end
            S_SDIV1: begin
                w_div_go  = !r_issued;
                w_div_ctl = '{start: w_div_go, frac: 1'b0};
                w_div_num = r_c;
                w_div_den = 64'(w_2n);
            end
            S_SDIV2: begin
                w_div_go  = !r_issued;
                w_div_ctl = '{start: w_div_go, frac: 1'b0};
                w_div_num = r_t;
                w_div_den = 64'(w_2n);
            end
            S_SDIV3: begin
                w_div_go  = !r_issued;
                w_div_ctl = '{start: w_div_go, frac: 1'b0};
                w_div_num = r_t;
                w_div_den = 64'(w_2np1);
            end
            S_LEN: begin
                w_sqrt_go = !r_issued;
                w_rad     = {64'd0, r_sq[r_i]};
            end
            S_YSQRT: begin
                w_sqrt_go = !r_issued;
                w_rad     = {4'd0, r_t, 60'd0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_issued <= 1'b0;
                    if (start) begin
                        for (int k = 0; k < 6; k++) begin
                            r_mag[k] <= w_dmag[k];
                            r_neg[k] <= w_d[k][DW-1];
                        end
                        r_degen <= 1'b0;
                        r_state <= S_NMAX;
                    end
                end
                S_NMAX: begin
                    r_m    <= w_max;
                    r_down <= (w_max >= LIM_HI);
                    if (w_max == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NSHIFT;
                    end
                end
                S_NSHIFT: begin
                    r_i <= 2'd0;
                    if (r_down) begin
                        if (r_m >= LIM_HI) begin
                            r_m <= r_m >> 1;
                            for (int k = 0; k < 4; k++) r_mag[k] <= r_mag[k] >> 1;
                        end else begin
                            r_state <= S_NFIX;
                        end
                    end else begin
                        if (r_m < LIM_LO) begin
                            r_m <= r_m << 1;
                            for (int k = 0; k < 6; k++) r_mag[k] <= r_mag[k] << 1;
                        end else begin
                            r_state <= S_SQU;
                        end
                    end
                end
                S_NFIX: begin
                    r_mag[4] <= MW'(w_f4[MW+1] ? -w_f4 : w_f4);
                    r_mag[5] <= MW'(w_f5[MW+1] ? -w_f5 : w_f5);
                    r_state  <= S_SQU;
                end
                S_SQU: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued <= 1'b0;
                        r_t      <= w_prod[63:0];
                        r_state  <= S_SQV;
                    end
                end
                S_SQV: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued   <= 1'b0;
                        r_sq[r_i]  <= r_t + w_prod[63:0];
                        r_state    <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_sqrt_done) begin
                        r_issued  <= 1'b0;
                        r_ln[r_i] <= w_root[31:0];
                        if (r_i == 2'd2) r_state <= S_TRI;
                        else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= S_SQU;
                        end
                    end
                end
                S_TRI: begin
                    r_i <= 2'd0;
                    if (w_degen_tri) begin
                        r_degen <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued  <= 1'b0;
                        r_den     <= {w_prod[62:0], 1'b0};
                        r_num_neg <= w_num[63];
                        r_state   <= S_DIVR;
                    end
                end
                S_DIVR: begin
                    if (!r_issued) begin
                        if (w_rone) begin
                            r_u     <= ONE_Q;
                            r_state <= S_AMAG;
                        end else begin
                            r_issued <= 1'b1;
                        end
                    end else if (w_div_done) begin
                        r_issued <= 1'b0;
                        r_u      <= w_quo;
                        r_state  <= S_AMAG;
                    end
                end
                S_AMAG: begin
                    if (r_u >= ONE_Q) begin
                        r_asin  <= PI_HALF_Q;
                        r_state <= S_AFIN;
                    end else if (r_u == 64'd0) begin
                        r_asin  <= '0;
                        r_state <= S_AFIN;
                    end else if (r_u <= SWITCH_Q) begin
                        r_flip  <= 1'b0;
                        r_state <= S_SXX;
                    end else begin
                        r_flip  <= 1'b1;
                        r_state <= S_YMUL;
                    end
                end
                S_YMUL: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued <= 1'b0;
                        r_t      <= ONE_Q - w_mulq;
                        r_state  <= S_YSQRT;
                    end
                end
                S_YSQRT: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_sqrt_done) begin
                        r_issued <= 1'b0;
                        r_u      <= w_root;
                        r_state  <= S_SXX;
                    end
                end
                S_SXX: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued <= 1'b0;
                        r_xx     <= w_mulq;
                        r_sum    <= r_u;
                        r_p      <= r_u;
                        r_c      <= ONE_Q;
                        r_n      <= 9'd1;
                        r_state  <= S_SDIV1;
                    end
                end
                S_SDIV1: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_div_done) begin
                        r_issued <= 1'b0;
                        r_q      <= w_quo;
                        r_t      <= 64'(w_rem[9:0] * w_2nm1);
                        r_state  <= S_SMUL1;
                    end
                end
                S_SMUL1: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued <= 1'b0;
                        r_q      <= w_prod[63:0];
                        r_state  <= S_SDIV2;
                    end
                end
                S_SDIV2: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_div_done) begin
                        r_issued <= 1'b0;
                        r_c      <= r_q + w_quo;
                        r_state  <= S_SMUL2;
                    end
                end
                S_SMUL2: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued <= 1'b0;
                        r_p      <= w_mulq;
                        r_state  <= S_SMUL3;
                    end
                end
                S_SMUL3: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_mul_done) begin
                        r_issued <= 1'b0;
                        r_t      <= w_mulq;
                        r_state  <= S_SDIV3;
                    end
                end
                S_SDIV3: begin
                    if (!r_issued) r_issued <= 1'b1;
                    else if (w_div_done) begin
                        r_issued <= 1'b0;
                        r_t      <= w_quo;
                        r_state  <= S_SACC;
                    end
                end
                S_SACC: begin
                    if (r_t == 64'd0) begin
                        r_state <= S_SFIN;
                    end else begin
                        r_sum <= r_sum + r_t;
                        if (r_n == N_LAST) r_state <= S_SFIN;
                        else begin
                            r_n     <= r_n + 9'd1;
                            r_state <= S_SDIV1;
                        end
                    end
                end
                S_SFIN: begin
                    r_asin  <= r_flip ? (PI_HALF_Q - r_sum) : r_sum;
                    r_state <= S_AFIN;
                end
                S_AFIN: begin
                    r_ang[r_i] <= w_rnd[31:0];
                    if (r_i == 2'd2) r_state <= S_DONE;
                    else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_DEN;
                    end
                end
                S_DONE: begin
                    r_strobe <= 1'b1;
                    if (r_degen) begin
                        r_result <= '{angle_a: 32'd0, angle_b: 32'd0, angle_c: 32'd0,
                                      degenerate: 1'b1};
                    end else begin
                        r_result <= '{angle_a: r_ang[0], angle_b: r_ang[1],
                                      angle_c: r_ang[2], degenerate: 1'b0};
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `TAV_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `TAV_ASSERT_IMM(a_strobe_idle, o_strobe, !busy, "result shown while still busy")
    `TAV_ASSERT_NXT(a_single_strobe, o_strobe, !o_strobe, "result strobe longer than one cycle")
    `TAV_ASSERT_IMM(a_degen_zero, o_strobe && o_result.degenerate,
        o_result.angle_a == 32'd0 && o_result.angle_b == 32'd0 && o_result.angle_c == 32'd0,
        "degenerate result with nonzero angles")
    `TAV_ASSERT_IMM(a_one_unit, 1'b1, $countones({w_mul_go, w_div_go, w_sqrt_go}) <= 1,
        "more than one shared unit started")

endmodule

`default_nettype wire

@@ verif/tav_checker.sv @@
// checker for the triangle angle block: predicts angles from accepted vertex transactions
// and compares them with each result strobe; depends on tav_pkg only
`timescale 1ns / 1ps

module tav_checker import tav_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 30
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     busy,
    input  t_tri_in  i_data,
    input  logic     o_strobe,
    input  t_tri_out o_result,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_degen_count,
    output int       o_result_count
);

    t_tri_out angles_due[$];

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] v, int top);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] sq;
        res = '0;
        for (int b = top; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            sq = {64'b0, cand} * {64'b0, cand};
            if (sq <= v) res = cand;
        end
        return res;
    endfunction

    function automatic logic [63:0] asin_taylor(logic [63:0] u);
        logic [63:0] sum, p, c, xx, two_n, q, r, term;
        sum = u;
        p = u;
        c = ONE_Q;
        xx = fx_mul(u, u);
        for (int n = 1; n <= MAX_TERMS; n++) begin
            two_n = 64'(2 * n);
            q = c / two_n;
            r = c % two_n;
            c = q * (two_n - 1) + (r * (two_n - 1)) / two_n;
            p = fx_mul(p, xx);
            term = fx_mul(c, p) / (two_n + 1);
            if (term == 0) break;
            sum += term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] asin_of_mag(logic [63:0] u);
        logic [63:0] y, s;
        if (u >= ONE_Q) return PI_HALF_Q;
        if (u == 0) return '0;
        if (u <= SWITCH_Q) return asin_taylor(u);
        y = ONE_Q - fx_mul(u, u);
        s = floor_root({64'b0, y} << QB, QB);
        return PI_HALF_Q - asin_taylor(s);
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] acos_ratio(longint num, logic [63:0] den);
        logic [63:0] m, r, a;
        m = magnitude(num);
        r = '0;
        if (m >= den) begin
            r = ONE_Q;
        end else begin
            for (int i = 0; i < QB; i++) begin
                m = m << 1;
                r = r << 1;
                if (m >= den) begin
                    m -= den;
                    r[0] = 1'b1;
                end
            end
        end
        a = (num >= 0) ? PI_HALF_Q - asin_of_mag(r) : PI_HALF_Q + asin_of_mag(r);
        a = (a + (64'd1 << (QB - 1 - ANGLE_FRAC_BITS))) >> (QB - ANGLE_FRAC_BITS);
        return a[31:0];
    endfunction

    function automatic t_tri_out triangle_angles(t_tri_in x);
        t_tri_out    res;
        longint      d[6];
        logic [63:0] m, u, v, sq[3], ln[3], t;
        int          s;
        res = '0;
        res.degenerate = 1'b1;
        d[0] = longint'(x.b_x) - longint'(x.a_x);
        d[1] = longint'(x.b_y) - longint'(x.a_y);
        d[2] = longint'(x.c_x) - longint'(x.a_x);
        d[3] = longint'(x.c_y) - longint'(x.a_y);
        d[4] = longint'(x.c_x) - longint'(x.b_x);
        d[5] = longint'(x.c_y) - longint'(x.b_y);
        m = '0;
        s = 0;
        for (int i = 0; i < 6; i++)
            if (magnitude(d[i]) > m) m = magnitude(d[i]);
        if (m == 0) return res;
        if (m >= 64'(NORM_LIM)) begin
            while ((m >> s) >= 64'(NORM_LIM)) s++;
            for (int i = 0; i < 4; i++) begin
                t = magnitude(d[i]) >> s;
                d[i] = d[i] < 0 ? -longint'(t) : longint'(t);
            end
            d[4] = d[2] - d[0];
            d[5] = d[3] - d[1];
        end else begin
            while ((m << s) < 64'(NORM_LIM >> 1)) s++;
            for (int i = 0; i < 6; i++) d[i] = d[i] * (longint'(1) << s);
        end
        for (int i = 0; i < 3; i++) begin
            u = magnitude(d[2*i]);
            v = magnitude(d[2*i+1]);
            sq[i] = u * u + v * v;
            ln[i] = floor_root({64'b0, sq[i]}, 31);
        end
        if (sq[0] == 0 || sq[1] == 0 || sq[2] == 0 ||
            ln[0] + ln[1] <= ln[2] || ln[0] + ln[2] <= ln[1] || ln[1] + ln[2] <= ln[0])
            return res;
        res.angle_a = acos_ratio(longint'(sq[0]) + longint'(sq[1]) - longint'(sq[2]),
                                 2 * ln[0] * ln[1]);
        res.angle_b = acos_ratio(longint'(sq[0]) + longint'(sq[2]) - longint'(sq[1]),
                                 2 * ln[0] * ln[2]);
        res.angle_c = acos_ratio(longint'(sq[1]) + longint'(sq[2]) - longint'(sq[0]),
                                 2 * ln[1] * ln[2]);
        res.degenerate = 1'b0;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch on %s at %0t: expected %h got %h", what, $realtime, want, got);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_degen_count = 0;
        o_result_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_tri_out want;
        if (i_rst_n) begin
            if (start && !busy) angles_due.push_back(triangle_angles(i_data));
            if (o_strobe) begin
                o_result_count++;
                if (angles_due.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    want = angles_due.pop_front();
                    if (want.degenerate) o_degen_count++;
                    if (o_result.angle_a !== want.angle_a)
                        report("angle_a", want.angle_a, o_result.angle_a);
                    if (o_result.angle_b !== want.angle_b)
                        report("angle_b", want.angle_b, o_result.angle_b);
                    if (o_result.angle_c !== want.angle_c)
                        report("angle_c", want.angle_c, o_result.angle_c);
                    if (o_result.degenerate !== want.degenerate)
                        report("degenerate", 32'(want.degenerate), 32'(o_result.degenerate));
                end
            end
            o_pending = angles_due.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// top of the triangle angle testbench: clock, reset, vertex stimulus and verdict
// depends on tav_pkg, tav_checker and the triangle_angles_from_vertices rtl
`timescale 1ns / 1ps

module testbench;
    import tav_pkg::*;

    localparam int  N_RANDOM  = 400;
    localparam longint LIMIT  = 400_000_000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_tri_in  i_data;
    logic     busy;
    logic     o_strobe;
    t_tri_out o_result;
    int       fail_count, pending, degen_count, result_count;
    int       sent;
    longint   cycles;

    triangle_angles_from_vertices i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_data(i_data),
        .busy(busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    tav_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_data(i_data),
        .o_strobe(o_strobe), .o_result(o_result), .o_fail_count(fail_count),
        .o_pending(pending), .o_degen_count(degen_count), .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic t_tri_in vertices(int ax, int ay, int bx, int by, int cx, int cy);
        t_tri_in t;
        t.a_x = ax; t.a_y = ay; t.b_x = bx; t.b_y = by; t.c_x = cx; t.c_y = cy;
        return t;
    endfunction

    function automatic t_tri_in random_triangle();
        t_tri_in t;
        int      base_x, base_y, span, kind;
        kind = $urandom_range(99);
        base_x = $urandom;
        base_y = $urandom;
        if (kind < 25) begin
            t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (kind < 75) begin
            span = $urandom_range(30, 1);
            t = vertices(base_x >>> 2, base_y >>> 2,
                         (base_x >>> 2) + ($urandom % (1 << span)) - (1 << (span - 1)),
                         (base_y >>> 2) + ($urandom % (1 << span)) - (1 << (span - 1)),
                         (base_x >>> 2) + ($urandom % (1 << span)) - (1 << (span - 1)),
                         (base_y >>> 2) + ($urandom % (1 << span)) - (1 << (span - 1)));
        end else if (kind < 88) begin
            span = $urandom_range(12, 1);
            t = vertices(base_x, base_y, base_x + span, base_y + 2 * span,
                         base_x + 2 * span + $urandom_range(2), base_y + 4 * span);
        end else if (kind < 95) begin
            t = vertices(base_x, base_y, base_x + $urandom_range(3), base_y,
                         base_x, base_y + $urandom_range(3));
        end else begin
            t = vertices(base_x, base_y, base_x, base_y, base_x, base_y);
        end
        return t;
    endfunction

    // one transaction: hold start until the block takes it, then gap per idle rate
    task automatic send(t_tri_in t, int idle_pct);
        start <= 1'b1;
        i_data <= t;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_data <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_tri_in directed[$];
        int      idle_pct;
        sent = 0;
        start = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(vertices(0, 0, 0, 0, 0, 0));
        directed.push_back(vertices(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                    32'h7fffffff, 32'h80000000));
        directed.push_back(vertices(0, 0, 0, 0, 1 << 16, 0));
        directed.push_back(vertices(0, 0, 1 << 16, 1 << 16, 2 << 16, 2 << 16));
        directed.push_back(vertices(0, 0, 3 << 16, 0, 0, 4 << 16));
        directed.push_back(vertices(0, 0, 2 << 16, 0, 1 << 16, 113512));
        directed.push_back(vertices(0, 0, 1, 0, 0, 1));
        directed.push_back(vertices(-1, -1, 0, 0, 1, -1));
        directed.push_back(vertices(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                    32'h80000000, 32'h7fffffff));
        directed.push_back(vertices(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                    32'h7fffffff, 32'h80000000));
        directed.push_back(vertices(0, 0, 1 << 20, 1, 1 << 21, 0));
        directed.push_back(vertices(0, 0, 1000, 0, 500, 1));
        directed.push_back(vertices(0, 0, 1000, 0, 1000, 10));
        directed.push_back(vertices(0, 0, 1 << 20, 0, 100, 1 << 20));
        directed.push_back(vertices(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                                    32'h55555555, 32'h55555555));
        directed.push_back(vertices(32'haaaaaaaa, 32'h55555555, 32'h12345678, 32'hedcba987,
                                    32'hffffffff, 32'h00000001));
        directed.push_back(vertices(5, 5, 5, 5 + (1 << 29), 5 + (1 << 29), 5));
        directed.push_back(vertices(0, 0, 1 << 28, 0, (1 << 28) - 1, 1));
        foreach (directed[k]) send(directed[k], 0);
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_pct = n < N_RANDOM / 3 ? 15 : (n < 2 * N_RANDOM / 3 ? 80 : 0);
            if (n == N_RANDOM / 2) drain();
            send(random_triangle(), idle_pct);
        end
        drain();
        repeat (50) @(posedge i_clk);

        $display("sent %0d triangles, %0d results checked, %0d flagged degenerate",
                 sent, result_count, degen_count);
        $display("idle mixes: light sender gaps, heavy sender gaps, back to back");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tav_pkg.sv
rtl/tav_mul.sv
rtl/tav_div.sv
rtl/tav_sqrt.sv
rtl/triangle_angles_from_vertices.sv
verif/tav_checker.sv
verif/testbench.sv
